>>> hw/rtl/mfft_pkg.sv
// Shared types, constants and register codes of the motor feedback frame tracker.
package mfft_pkg;

  localparam int MOTORS_PER_BUS = 6;
  localparam int BUS_COUNT      = 4;
  localparam int NUM_ENTRIES    = BUS_COUNT * MOTORS_PER_BUS;
  localparam int IDX_W          = $clog2(NUM_ENTRIES);
  localparam int TURN_W         = 32;
  localparam int COUNT_W        = 16;
  localparam int ENTRY_W        = TURN_W + COUNT_W;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 17;

  localparam logic [10:0] ID_BASE_RST   = 11'h140;
  localparam logic [7:0]  CODE_MA_RST   = 8'd146;
  localparam logic [7:0]  CODE_CUR_RST  = 8'd161;
  localparam logic [7:0]  CODE_VEL_RST  = 8'd162;
  localparam logic [16:0] CPT_RST       = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ID_BASE         = 3'd0,
    CFG_CODE_MULTI      = 3'd1,
    CFG_CODE_CURRENT    = 3'd2,
    CFG_CODE_VELOCITY   = 3'd3,
    CFG_COUNTS_PER_TURN = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_UPDATE    = 2'd0,
    ST_ANGLE     = 2'd1,
    ST_BAD_MOTOR = 2'd2,
    ST_OTHER     = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_CALC = 1'b1
  } state_t;

  typedef struct packed {
    logic [10:0] id_base;
    logic [7:0]  code_ma;
    logic [7:0]  code_cur;
    logic [7:0]  code_vel;
    logic [16:0] counts_per_turn;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       bus;
    logic [7:0]       motor;
    logic [IDX_W-1:0] idx;
    logic             bad;
    logic [63:0]      data;
  } item_t;

  typedef struct packed {
    logic [TURN_W-1:0]  turns;
    logic [COUNT_W-1:0] last_count;
  } entry_t;

  typedef struct packed {
    status_t     status;
    logic [1:0]  bus_out;
    logic [7:0]  motor_number;
    logic [7:0]  temperature;
    logic [15:0] phase_current;
    logic [15:0] rotor_speed;
    logic [15:0] encoder_count;
    logic [31:0] turns;
    logic [55:0] multi_angle_raw;
  } result_t;

endpackage

>>> hw/rtl/mfft_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mfft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/mfft_update.sv
// Turn tracking and result formatting for one frame against its stored entry.
module mfft_update (
  input  mfft_pkg::item_t   item,
  input  mfft_pkg::cfg_t    cfg,
  input  mfft_pkg::entry_t  entry,
  output mfft_pkg::result_t res,
  output mfft_pkg::entry_t  wr_entry,
  output logic              wr_en
);
  import mfft_pkg::*;

  logic [7:0]         code;
  logic               is_ma;
  logic               is_tv;
  logic [15:0]        enc_bits;
  logic signed [17:0] diff;
  logic signed [17:0] half;
  logic [TURN_W-1:0]  turns_upd;

  always_comb begin
    code  = item.data[7:0];
    is_ma = (code == cfg.code_ma);
    is_tv = (code == cfg.code_cur) || (code == cfg.code_vel);
    enc_bits = item.data[63:48];
    diff = 18'(signed'(enc_bits)) - 18'(signed'(entry.last_count));
    half = signed'({2'b00, cfg.counts_per_turn[16:1]});

    // An upward jump past half a turn means the count wrapped backward.
    turns_upd = entry.turns;
    if (diff > half) begin
      turns_upd = entry.turns - TURN_W'(1);
    end else if (diff < -half) begin
      turns_upd = entry.turns + TURN_W'(1);
    end

    wr_en = !item.bad && is_tv;
    wr_entry.turns      = turns_upd;
    wr_entry.last_count = enc_bits;

    res = '0;
    res.bus_out      = item.bus;
    res.motor_number = item.motor;
    if (item.bad) begin
      res.status = ST_BAD_MOTOR;
    end else begin
      if (is_ma) begin
        res.multi_angle_raw = item.data[63:8];
      end
      if (is_tv) begin
        res.status        = ST_UPDATE;
        res.temperature   = item.data[15:8];
        res.phase_current = item.data[31:16];
        res.rotor_speed   = item.data[47:32];
        res.encoder_count = enc_bits;
        res.turns         = turns_upd;
      end else begin
        res.status = is_ma ? ST_ANGLE : ST_OTHER;
        res.turns  = entry.turns;
      end
    end
  end

endmodule

>>> hw/rtl/motor_feedback_frame_tracker.sv
// Top level of the motor feedback frame tracker: control, configuration and state memory.
// Each accepted item yields exactly one result item. Accepting an item reads the motor's
// entry (turn count and previous encoder count) from the state memory; the compute state
// then computes the result and writes the entry back. No new item is taken until the
// compute state is left. The result sits in an output register; the next item may be
// accepted while it waits, and its compute state is held until the output register is
// free. All entries read as zero after reset, with no clearing pass.
module motor_feedback_frame_tracker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_bus_index,
  input  logic [10:0] in_message_id,
  input  logic [63:0] in_frame_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [1:0]  out_bus_out,
  output logic [7:0]  out_motor_number,
  output logic signed [7:0]  out_temperature,
  output logic signed [15:0] out_phase_current,
  output logic signed [15:0] out_rotor_speed,
  output logic signed [15:0] out_encoder_count,
  output logic signed [31:0] out_turns,
  output logic signed [55:0] out_multi_angle_raw,
  input  logic        cfg_we,
  input  logic [mfft_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mfft_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mfft_pkg::*;

  state_t               state_r, state_nxt;
  cfg_t                 cfg_r;
  item_t                item_r, item_dec;
  logic                 rd_valid_r;
  logic [NUM_ENTRIES-1:0] valid_r;
  logic                 out_valid_r;
  result_t              res_r, res_calc;
  entry_t               entry_rd, wr_entry;
  logic [ENTRY_W-1:0]   ram_q;
  logic                 wr_en, ram_we;
  logic                 accept, proceed;
  logic [7:0]           idx_sum;
  logic [10:0]          id_diff;

  // Frame decode on the input side.
  always_comb begin
    id_diff        = in_message_id - cfg_r.id_base;
    item_dec.bus   = in_bus_index;
    item_dec.motor = id_diff[7:0];
    item_dec.data  = in_frame_data;
    item_dec.bad   = (item_dec.motor == 8'd0) ||
                     (item_dec.motor > 8'(MOTORS_PER_BUS)) ||
                     ({1'b0, in_bus_index} >= 3'(BUS_COUNT));
    idx_sum        = 8'(in_bus_index) * 8'(MOTORS_PER_BUS) + item_dec.motor - 8'd1;
    item_dec.idx   = idx_sum[IDX_W-1:0];
  end

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign proceed  = (state_r == S_CALC) && (!out_valid_r || out_ready);
  assign ram_we   = proceed && wr_en;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_CALC;
      S_CALC: if (proceed) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.id_base         <= ID_BASE_RST;
      cfg_r.code_ma         <= CODE_MA_RST;
      cfg_r.code_cur        <= CODE_CUR_RST;
      cfg_r.code_vel        <= CODE_VEL_RST;
      cfg_r.counts_per_turn <= CPT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ID_BASE:         cfg_r.id_base         <= cfg_wdata[10:0];
        CFG_CODE_MULTI:      cfg_r.code_ma         <= cfg_wdata[7:0];
        CFG_CODE_CURRENT:    cfg_r.code_cur        <= cfg_wdata[7:0];
        CFG_CODE_VELOCITY:   cfg_r.code_vel        <= cfg_wdata[7:0];
        CFG_COUNTS_PER_TURN: cfg_r.counts_per_turn <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_dec;
    end
  end

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (ram_we) begin
        valid_r[item_r.idx] <= 1'b1;
      end
      if (accept) begin
        rd_valid_r <= !item_dec.bad && valid_r[item_dec.idx];
      end
    end
  end

  mfft_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NUM_ENTRIES)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (item_r.idx),
    .wdata (wr_entry),
    .re    (accept),
    .raddr (item_dec.idx),
    .rdata (ram_q)
  );

  assign entry_rd = rd_valid_r ? entry_t'(ram_q) : '0;

  mfft_update u_update (
    .item     (item_r),
    .cfg      (cfg_r),
    .entry    (entry_rd),
    .res      (res_calc),
    .wr_entry (wr_entry),
    .wr_en    (wr_en)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proceed) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed) begin
      res_r <= res_calc;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = res_r.status;
  assign out_bus_out         = res_r.bus_out;
  assign out_motor_number    = res_r.motor_number;
  assign out_temperature     = res_r.temperature;
  assign out_phase_current   = res_r.phase_current;
  assign out_rotor_speed     = res_r.rotor_speed;
  assign out_encoder_count   = res_r.encoder_count;
  assign out_turns           = res_r.turns;
  assign out_multi_angle_raw = res_r.multi_angle_raw;

`ifndef SYNTHESIS
  a_accept_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_CALC))
    else $error("accepted item did not move to the compute cycle");

  a_write_only_good: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CALC) && !item_r.bad)
    else $error("state memory written outside a valid update");

  a_result_from_calc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CALC) && out_valid_r && !out_ready |=> (state_r == S_CALC))
    else $error("compute cycle left while output register was full");
`endif

endmodule

>>> dv/tb.sv
// Self-checking testbench for the motor feedback frame tracker.
module tb;
  import mfft_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_bus_index = '0;
  logic [10:0] in_message_id = '0;
  logic [63:0] in_frame_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [1:0]  out_bus_out;
  logic [7:0]  out_motor_number;
  logic signed [7:0]  out_temperature;
  logic signed [15:0] out_phase_current;
  logic signed [15:0] out_rotor_speed;
  logic signed [15:0] out_encoder_count;
  logic signed [31:0] out_turns;
  logic signed [55:0] out_multi_angle_raw;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Tracker state as the testbench sees it.
  cfg_t        tracker_cfg;
  logic [31:0] turn_count [NUM_ENTRIES];
  logic [15:0] prev_encoder [NUM_ENTRIES];
  result_t     expected_results [$];
  // Last encoder count sent per bus and motor, used only to shape stimulus.
  logic [15:0] encoder_hint [32];

  int mismatch_count = 0;
  int cycle_count = 0;
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;

  motor_feedback_frame_tracker u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_bus_index        (in_bus_index),
    .in_message_id       (in_message_id),
    .in_frame_data       (in_frame_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_bus_out         (out_bus_out),
    .out_motor_number    (out_motor_number),
    .out_temperature     (out_temperature),
    .out_phase_current   (out_phase_current),
    .out_rotor_speed     (out_rotor_speed),
    .out_encoder_count   (out_encoder_count),
    .out_turns           (out_turns),
    .out_multi_angle_raw (out_multi_angle_raw),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= rst_n && ($urandom_range(0, 99) >= receiver_idle_pct);
  end

  // Works out the result of one frame and updates the per-motor turn state.
  function automatic result_t track_frame(logic [1:0] bus, logic [10:0] mid, logic [63:0] data);
    result_t r;
    logic [7:0] motor;
    int entry;
    int enc;
    int prev;
    int half;
    logic is_angle;
    logic is_update;
    r = '0;
    motor = 8'(mid - tracker_cfg.id_base);
    r.bus_out = bus;
    r.motor_number = motor;
    if (motor == 8'd0 || motor > MOTORS_PER_BUS) begin
      r.status = ST_BAD_MOTOR;
      return r;
    end
    entry = int'(bus) * MOTORS_PER_BUS + int'(motor) - 1;
    is_angle = (data[7:0] == tracker_cfg.code_ma);
    is_update = (data[7:0] == tracker_cfg.code_cur) || (data[7:0] == tracker_cfg.code_vel);
    if (is_angle)
      r.multi_angle_raw = data[63:8];
    if (is_update) begin
      enc = int'($signed(data[63:48]));
      prev = int'($signed(prev_encoder[entry]));
      half = int'(tracker_cfg.counts_per_turn >> 1);
      // An upward jump past half a turn means the count wrapped backward.
      if (enc - prev > half)
        turn_count[entry] = turn_count[entry] - 32'd1;
      if (enc - prev < -half)
        turn_count[entry] = turn_count[entry] + 32'd1;
      prev_encoder[entry] = data[63:48];
      r.status = ST_UPDATE;
      r.temperature = data[15:8];
      r.phase_current = data[31:16];
      r.rotor_speed = data[47:32];
      r.encoder_count = data[63:48];
    end else if (is_angle) begin
      r.status = ST_ANGLE;
    end else begin
      r.status = ST_OTHER;
    end
    r.turns = turn_count[entry];
    return r;
  endfunction

  function automatic void compare_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (in_valid && in_ready)
        expected_results.insert(expected_results.size(),
                                track_frame(in_bus_index, in_message_id, in_frame_data));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result item with nothing expected, status %0h motor %0h", $time,
                   out_status, out_motor_number);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("status", want.status, out_status);
          compare_field("bus_out", want.bus_out, out_bus_out);
          compare_field("motor_number", want.motor_number, out_motor_number);
          compare_field("temperature", want.temperature, $unsigned(out_temperature));
          compare_field("phase_current", want.phase_current, $unsigned(out_phase_current));
          compare_field("rotor_speed", want.rotor_speed, $unsigned(out_rotor_speed));
          compare_field("encoder_count", want.encoder_count, $unsigned(out_encoder_count));
          compare_field("turns", want.turns, $unsigned(out_turns));
          compare_field("multi_angle_raw", want.multi_angle_raw,
                        $unsigned(out_multi_angle_raw));
        end
      end
    end
  end

  function automatic logic [63:0] update_payload(logic [7:0] code, logic [7:0] temp,
                                                 logic [15:0] current, logic [15:0] speed,
                                                 logic [15:0] enc);
    return {enc, speed, current, temp, code};
  endfunction

  task automatic send_frame(logic [1:0] bus, logic [10:0] mid, logic [63:0] data);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_bus_index <= bus;
    in_message_id <= mid;
    in_frame_data <= data;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    do
      @(posedge clk);
    while (expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Registers are only written with the tracker idle.
  task automatic write_reg(cfg_idx_t which, logic [16:0] value);
    wait_until_drained();
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (which)
      CFG_ID_BASE:         tracker_cfg.id_base = value[10:0];
      CFG_CODE_MULTI:      tracker_cfg.code_ma = value[7:0];
      CFG_CODE_CURRENT:    tracker_cfg.code_cur = value[7:0];
      CFG_CODE_VELOCITY:   tracker_cfg.code_vel = value[7:0];
      CFG_COUNTS_PER_TURN: tracker_cfg.counts_per_turn = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic test_default_codes();
    send_frame(2'd0, 11'd321, update_payload(CODE_CUR_RST, 8'h7F, 16'h8000, 16'h7FFF, 16'h0100));
    send_frame(2'd3, 11'd326, {56'hFF_FFFF_FFFF_FFFF, CODE_VEL_RST});
    send_frame(2'd1, 11'd323, {56'h80_0000_0000_0000, CODE_MA_RST});
    send_frame(2'd1, 11'd323, {56'h7F_FFFF_FFFF_FFFF, CODE_MA_RST});
    send_frame(2'd2, 11'd322, 64'h0);
    send_frame(2'd0, 11'd320, update_payload(CODE_CUR_RST, 8'h80, 16'h1234, 16'h5678, 16'h9ABC));
    send_frame(2'd0, 11'd327, {$urandom, $urandom});
    send_frame(2'd1, 11'd0, {$urandom, $urandom});
    send_frame(2'd2, 11'd2047, {$urandom, $urandom});
  endtask

  task automatic test_turn_steps();
    write_reg(CFG_COUNTS_PER_TURN, 17'd4);
    send_frame(2'd2, 11'd324, update_payload(CODE_CUR_RST, 8'd0, 16'd0, 16'd0, 16'd0));
    // Stepping down from zero takes the turn count through its wrap.
    send_frame(2'd2, 11'd324, update_payload(CODE_CUR_RST, 8'd0, 16'd0, 16'd0, 16'd3));
    send_frame(2'd2, 11'd324, update_payload(CODE_VEL_RST, 8'd0, 16'd0, 16'd0, 16'd0));
    send_frame(2'd2, 11'd324, update_payload(CODE_CUR_RST, 8'd0, 16'd0, 16'd0, 16'd2));
    send_frame(2'd2, 11'd324, update_payload(CODE_CUR_RST, 8'd0, 16'd0, 16'd0, 16'h8000));
    send_frame(2'd2, 11'd324, update_payload(CODE_VEL_RST, 8'd0, 16'd0, 16'd0, 16'h7FFF));
    // A zero threshold steps the turns on any change at all.
    write_reg(CFG_COUNTS_PER_TURN, 17'd0);
    send_frame(2'd2, 11'd324, update_payload(CODE_CUR_RST, 8'd0, 16'd0, 16'd0, 16'h7FFF));
    send_frame(2'd2, 11'd324, update_payload(CODE_CUR_RST, 8'd0, 16'd0, 16'd0, 16'h7FFE));
    // With the widest setting even a full-range swing stays on the same turn.
    write_reg(CFG_COUNTS_PER_TURN, 17'h1FFFF);
    send_frame(2'd2, 11'd324, update_payload(CODE_CUR_RST, 8'd0, 16'd0, 16'd0, 16'h7FFF));
    send_frame(2'd2, 11'd324, update_payload(CODE_CUR_RST, 8'd0, 16'd0, 16'd0, 16'h8000));
    write_reg(CFG_COUNTS_PER_TURN, 17'(CPT_RST));
  endtask

  task automatic test_code_overlap();
    write_reg(CFG_CODE_MULTI, 17'(CODE_CUR_RST));
    send_frame(2'd0, 11'd321, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_FF00 | CODE_CUR_RST);
    write_reg(CFG_CODE_MULTI, 17'(CODE_VEL_RST));
    send_frame(2'd3, 11'd325, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_FF00 | CODE_VEL_RST);
    write_reg(CFG_CODE_VELOCITY, 17'(CODE_CUR_RST));
    send_frame(2'd1, 11'd322, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_FF00 | CODE_CUR_RST);
    write_reg(CFG_CODE_MULTI, 17'(CODE_MA_RST));
    write_reg(CFG_CODE_VELOCITY, 17'(CODE_VEL_RST));
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_ID_BASE, 17'd0);
    send_frame(2'd0, 11'd1, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_FF00 | CODE_CUR_RST);
    send_frame(2'd1, 11'd2047, {$urandom, $urandom});
    write_reg(CFG_ID_BASE, 17'd2047);
    send_frame(2'd2, 11'd0, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_FF00 | CODE_MA_RST);
    write_reg(CFG_CODE_CURRENT, 17'd0);
    write_reg(CFG_CODE_VELOCITY, 17'd255);
    write_reg(CFG_CODE_MULTI, 17'd128);
    send_frame(2'd3, 11'd5, update_payload(8'd0, 8'h01, 16'h0002, 16'h0003, 16'h0004));
    send_frame(2'd3, 11'd5, update_payload(8'd255, 8'hFE, 16'hFFFD, 16'hFFFC, 16'hFFFB));
    send_frame(2'd3, 11'd5, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_FF00 | 64'd128);
  endtask

  task automatic send_random_frame();
    logic [1:0]  bus;
    logic [7:0]  motor;
    logic [10:0] mid;
    logic [7:0]  code;
    logic [15:0] enc;
    logic [63:0] data;
    logic [4:0]  slot;
    int roll;
    bus = 2'($urandom_range(0, 3));
    motor = 8'($urandom_range(1, MOTORS_PER_BUS));
    roll = $urandom_range(0, 99);
    if (roll < 80)
      mid = 11'(tracker_cfg.id_base + motor);
    else if (roll < 90)
      mid = 11'(tracker_cfg.id_base + (roll[0] ? 8'd0 : 8'(MOTORS_PER_BUS + 1)));
    else
      mid = 11'($urandom_range(0, 2047));
    roll = $urandom_range(0, 99);
    if (roll < 40)
      code = tracker_cfg.code_cur;
    else if (roll < 70)
      code = tracker_cfg.code_vel;
    else if (roll < 85)
      code = tracker_cfg.code_ma;
    else
      code = 8'($urandom);
    slot = {bus, motor[2:0]};
    roll = $urandom_range(0, 99);
    // Half the moves are small, a quarter jump by about half the encoder range, the rest are random.
    if (roll < 50)
      enc = encoder_hint[slot] + 16'($urandom_range(0, 600)) - 16'd300;
    else if (roll < 75)
      enc = encoder_hint[slot] + 16'h8000 + 16'($urandom_range(0, 4000)) - 16'd2000;
    else
      enc = 16'($urandom);
    encoder_hint[slot] = enc;
    data = {enc, 16'($urandom), 16'($urandom), 8'($urandom), code};
    send_frame(bus, mid, data);
  endtask

  task automatic randomize_config();
    logic [7:0] code_ma;
    int pick;
    code_ma = 8'($urandom);
    write_reg(CFG_ID_BASE, 17'($urandom_range(0, 2047)));
    write_reg(CFG_CODE_MULTI, 17'(code_ma));
    write_reg(CFG_CODE_CURRENT, $urandom_range(0, 9) == 0 ? 17'(code_ma) : 17'($urandom_range(0, 255)));
    write_reg(CFG_CODE_VELOCITY, 17'($urandom_range(0, 255)));
    pick = $urandom_range(0, 6);
    case (pick)
      0: write_reg(CFG_COUNTS_PER_TURN, 17'd4);
      1: write_reg(CFG_COUNTS_PER_TURN, 17'd65536);
      2: write_reg(CFG_COUNTS_PER_TURN, 17'h1FFFF);
      3: write_reg(CFG_COUNTS_PER_TURN, 17'd0);
      4: write_reg(CFG_COUNTS_PER_TURN, 17'd4096);
      default: write_reg(CFG_COUNTS_PER_TURN, 17'($urandom_range(4, 65536)));
    endcase
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct, int count);
    randomize_config();
    sender_idle_pct = send_pct;
    receiver_idle_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      // Now and then hold off until the tracker has returned everything.
      if ($urandom_range(0, 99) == 0)
        wait_until_drained();
      send_random_frame();
    end
  endtask

  initial begin
    tracker_cfg = '{ID_BASE_RST, CODE_MA_RST, CODE_CUR_RST, CODE_VEL_RST, CPT_RST};
    foreach (turn_count[i]) begin
      turn_count[i] = '0;
      prev_encoder[i] = '0;
    end
    foreach (encoder_hint[i])
      encoder_hint[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    sender_idle_pct = 23;
    receiver_idle_pct = 83;
    test_default_codes();
    test_turn_steps();
    test_code_overlap();
    test_register_extremes();
    test_random_traffic(23, 83, 400);
    test_random_traffic(83, 23, 400);
    test_random_traffic(0, 0, 400);
    wait_until_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
